/* src/hbkrd_pkg.sv */
// shared types, constants and lookup tables of the boot keyboard report decoder
package hbkrd_pkg;

    localparam int SLOT_MAX     = 6;
    localparam int MOD_COUNT    = 8;
    localparam int EV_BITS      = MOD_COUNT + 2 * SLOT_MAX + 1;
    localparam int EV_SYNC      = EV_BITS - 1;
    localparam int EV_IDX_W     = $clog2(EV_BITS);
    localparam int SLOT_W       = $clog2(SLOT_MAX);
    localparam int EMPTY_MAX    = 3;
    localparam int MOD_BASE     = 224;
    localparam int SEQ_POS_W    = 4;
    localparam int SEQ_DEPTH    = 16;
    localparam int SEQUENCE_LENGTH_DEF = 10;
    localparam int KEY_SLOTS_DEF       = 6;
    localparam int IN_DATA_W    = 8 + 8 * SLOT_MAX;
    localparam int OUT_DATA_W   = 16;

    // event kinds
    localparam logic [1:0] KIND_KEY       = 2'd0;
    localparam logic [1:0] KIND_UNK_REL   = 2'd1;
    localparam logic [1:0] KIND_UNK_PRESS = 2'd2;
    localparam logic [1:0] KIND_SYNC      = 2'd3;

    localparam logic [7:0] SEQ_TABLE [SEQ_DEPTH] = '{
        8'd103, 8'd103, 8'd108, 8'd108, 8'd105, 8'd106, 8'd105, 8'd106,
        8'd48,  8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

    localparam logic [7:0] SCAN_TABLE [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 8'd48, 8'd46, 8'd32,
        8'd18, 8'd33, 8'd34, 8'd35, 8'd23, 8'd36, 8'd37, 8'd38,
        8'd50, 8'd49, 8'd24, 8'd25, 8'd16, 8'd19, 8'd31, 8'd20,
        8'd22, 8'd47, 8'd17, 8'd45, 8'd21, 8'd44, 8'd2, 8'd3,
        8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
        8'd28, 8'd1, 8'd14, 8'd15, 8'd57, 8'd12, 8'd13, 8'd26,
        8'd27, 8'd43, 8'd43, 8'd39, 8'd40, 8'd41, 8'd51, 8'd52,
        8'd53, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64,
        8'd65, 8'd66, 8'd67, 8'd68, 8'd87, 8'd88, 8'd99, 8'd70,
        8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
        8'd105, 8'd108, 8'd103, 8'd69, 8'd98, 8'd55, 8'd74, 8'd78,
        8'd96, 8'd79, 8'd80, 8'd81, 8'd75, 8'd76, 8'd77, 8'd71,
        8'd72, 8'd73, 8'd82, 8'd83, 8'd86, 8'd127, 8'd116, 8'd117,
        8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
        8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
        8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
        8'd115, 8'd114, 8'd0, 8'd0, 8'd0, 8'd121, 8'd0, 8'd89,
        8'd93, 8'd124, 8'd92, 8'd94, 8'd95, 8'd0, 8'd0, 8'd0,
        8'd122, 8'd123, 8'd90, 8'd91, 8'd85, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126,
        8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
        8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
        8'd142, 8'd152, 8'd173, 8'd140, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // one classified report waiting for event generation
    typedef struct packed {
        logic [7:0]                mods;
        logic [SLOT_MAX-1:0][7:0]  prev;
        logic [SLOT_MAX-1:0][7:0]  now;
        logic [EV_BITS-1:0]        mask;
    } t_report;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       down;
        logic       done;
        logic       last;
    } t_event;

endpackage

/* src/hid_boot_keyboard_report_decoder_unit.sv */
// top level of the usb hid boot keyboard report decoder
// the first event of a report passes through the queue entry register and then the output register
// throughput: one event request per cycle while the output is not stalled; a report gives 9 to 21
// events, set by the front end event mask and walked by the back end
// the front end takes a new report every cycle while its two-entry queue has room
// reset (synchronous, active low) clears stored keys, sequence position, queue and output
module hid_boot_keyboard_report_decoder_unit #(
    parameter int SEQUENCE_LENGTH = hbkrd_pkg::SEQUENCE_LENGTH_DEF,
    parameter int KEY_SLOTS       = hbkrd_pkg::KEY_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // report requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // modifier_bits [7:0], key_slot_0 [15:8] .. key_slot_5 [55:48]
    input  logic [hbkrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // transfer_ok [0]
    input  logic                               s_axis_tuser,
    // event requests
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // key_code [7:0], key_down [8], sequence_done [9], zero [15:10]
    output logic [hbkrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // event_kind [1:0]
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import hbkrd_pkg::*;

    logic    w_q_ready;
    logic    w_push;
    t_report w_entry;
    logic    w_q_valid;
    t_report w_head;
    logic    w_pop;
    t_event  w_ev;

    // front end: diff against stored keys, failed transfers are dropped here
    hbkrd_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_ok      (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_q_ready (w_q_ready),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    // decouples report intake from event output
    hbkrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // back end: one event per cycle, when not stalled, into a registered output stage
    hbkrd_back #(
        .SEQUENCE_LENGTH (SEQUENCE_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_event (w_ev)
    );

    // pack the event fields onto the stream
    assign m_axis_tdata = {6'd0, w_ev.done, w_ev.down, w_ev.code};
    assign m_axis_tuser = w_ev.kind;
    assign m_axis_tlast = w_ev.last;

endmodule

/* src/hbkrd_front.sv */
// front end: accepts reports, diffs them against the stored keys, builds the event mask
module hbkrd_front #(
    parameter int KEY_SLOTS = hbkrd_pkg::KEY_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ok,
    input  logic [hbkrd_pkg::IN_DATA_W-1:0] i_data,
    input  logic                          i_q_ready,
    output logic                          o_ready,
    output logic                          o_push,
    output hbkrd_pkg::t_report            o_entry
);
    import hbkrd_pkg::*;

    logic [7:0]               r_prev [KEY_SLOTS];
    logic [SLOT_MAX-1:0][7:0] w_now;
    logic [SLOT_MAX-1:0][7:0] w_prev_flat;
    logic [SLOT_MAX-1:0]      w_rel;
    logic [SLOT_MAX-1:0]      w_prs;
    logic                     w_accept;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign o_push   = w_accept && i_ok;

    for (genvar gs = 0; gs < SLOT_MAX; gs++) begin : g_slot
        assign w_now[gs] = i_data[8 + 8 * gs +: 8];
        if (gs < KEY_SLOTS) begin : g_used
            logic [KEY_SLOTS-1:0] w_old_seen;
            logic [KEY_SLOTS-1:0] w_new_seen;
            for (genvar gj = 0; gj < KEY_SLOTS; gj++) begin : g_cmp
                assign w_old_seen[gj] = (i_data[8 + 8 * gj +: 8] == r_prev[gs]);
                assign w_new_seen[gj] = (r_prev[gj] == i_data[8 + 8 * gs +: 8]);
            end
            // stored key gone from the new report, new key not in the stored set
            assign w_rel[gs] = (r_prev[gs] > 8'(EMPTY_MAX)) && !(|w_old_seen);
            assign w_prs[gs] = (i_data[8 + 8 * gs +: 8] > 8'(EMPTY_MAX)) && !(|w_new_seen);
            assign w_prev_flat[gs] = r_prev[gs];
        end else begin : g_unused
            assign w_rel[gs]       = 1'b0;
            assign w_prs[gs]       = 1'b0;
            assign w_prev_flat[gs] = 8'h00;
        end
    end

    always_comb begin
        o_entry.mods = i_data[7:0];
        o_entry.prev = w_prev_flat;
        o_entry.now  = w_now;
        o_entry.mask[MOD_COUNT-1:0] = '1;
        for (int s = 0; s < SLOT_MAX; s++) begin
            o_entry.mask[MOD_COUNT + 2 * s]     = w_rel[s];
            o_entry.mask[MOD_COUNT + 2 * s + 1] = w_prs[s];
        end
        o_entry.mask[EV_SYNC] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_prev[k] <= 8'h00;
            end
        end else if (o_push) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_prev[k] <= w_now[k];
            end
        end
    end

endmodule

/* src/hbkrd_queue.sv */
// two-entry report queue between front and back ends
module hbkrd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hbkrd_pkg::t_report i_entry,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output hbkrd_pkg::t_report o_head
);
    import hbkrd_pkg::*;

    t_report    r_ent0;
    t_report    r_ent1;
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_rd ? r_ent1 : r_ent0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !r_wr) begin
            r_ent0 <= i_entry;
        end
        if (i_push && r_wr) begin
            r_ent1 <= i_entry;
        end
    end

endmodule

/* src/hbkrd_back.sv */
// back end: walks the event mask, translates scancodes, tracks the key sequence
module hbkrd_back #(
    parameter int SEQUENCE_LENGTH = hbkrd_pkg::SEQUENCE_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hbkrd_pkg::t_report i_head,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output hbkrd_pkg::t_event  o_event
);
    import hbkrd_pkg::*;

    logic [EV_BITS-1:0]   r_done;
    logic [SEQ_POS_W-1:0] r_pos;
    logic [SEQ_POS_W-1:0] n_pos;
    logic                 r_out_valid;
    t_event               r_out;
    t_event               w_ev;
    logic [EV_BITS-1:0]   w_pend;
    logic [EV_IDX_W-1:0]  w_idx;
    logic [EV_IDX_W-1:0]  w_rel_idx;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_is_mod;
    logic                 w_is_sync;
    logic                 w_press;
    logic [7:0]           w_raw;
    logic [7:0]           w_code;
    logic [SEQ_POS_W:0]   w_pos_inc;
    logic                 w_fire;

    assign w_fire = i_valid && (!r_out_valid || i_ready);
    assign w_pend = i_head.mask & ~r_done;

    // lowest pending event goes first
    always_comb begin
        w_idx = EV_IDX_W'(EV_SYNC);
        for (int k = EV_BITS - 1; k >= 0; k--) begin
            if (w_pend[k]) begin
                w_idx = EV_IDX_W'(k);
            end
        end
    end

    assign w_is_mod  = (w_idx < EV_IDX_W'(MOD_COUNT));
    assign w_is_sync = (w_idx == EV_IDX_W'(EV_SYNC));
    assign w_rel_idx = w_idx - EV_IDX_W'(MOD_COUNT);
    assign w_slot    = w_rel_idx[SLOT_W:1];
    assign w_press   = w_rel_idx[0];
    assign w_raw     = w_is_mod ? (8'(MOD_BASE) | {5'd0, w_idx[2:0]})
                     : (w_press ? i_head.now[w_slot] : i_head.prev[w_slot]);
    assign w_code    = SCAN_TABLE[w_raw];
    assign w_pos_inc = {1'b0, r_pos} + 1'b1;

    always_comb begin
        w_ev  = '0;
        n_pos = r_pos;
        if (w_is_sync) begin
            w_ev.kind = KIND_SYNC;
            w_ev.last = 1'b1;
        end else if (w_is_mod) begin
            w_ev.kind = KIND_KEY;
            w_ev.code = w_code;
            w_ev.down = i_head.mods[w_idx[2:0]];
        end else if (w_code == 8'h00) begin
            w_ev.kind = w_press ? KIND_UNK_PRESS : KIND_UNK_REL;
            w_ev.code = w_raw;
        end else begin
            w_ev.kind = KIND_KEY;
            w_ev.code = w_code;
            w_ev.down = w_press;
            if (!w_press) begin
                if (SEQ_TABLE[r_pos] == w_code) begin
                    if (w_pos_inc >= (SEQ_POS_W + 1)'(SEQUENCE_LENGTH)) begin
                        w_ev.done = 1'b1;
                        n_pos     = '0;
                    end else begin
                        n_pos = w_pos_inc[SEQ_POS_W-1:0];
                    end
                end else begin
                    n_pos = '0;
                end
            end
        end
    end

    assign o_pop   = w_fire && w_is_sync;
    assign o_valid = r_out_valid;
    assign o_event = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_pos       <= n_pos;
                if (w_is_sync) begin
                    r_done <= '0;
                end else begin
                    r_done[w_idx] <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_ev;
        end
    end

endmodule
